### hdl/htnm_pkg.sv
// Package for the height-to-normal-map block.
// Holds shared widths, constants, the state enums and the normal job type.
// No dependencies.
package htnm_pkg;

  localparam int MAX_WIDTH_DEF = 1024;
  localparam int GREY_W = 8;
  localparam int COL_W = 10;
  localparam int ROW_W = 16;
  localparam int WIDTH_REG_W = 11;
  localparam int SCALE_W = 9;
  localparam int CFG_ADDR_W = 4;

  // Register byte addresses.
  localparam logic [CFG_ADDR_W-1:0] REG_WIDTH = 4'h0;
  localparam logic [CFG_ADDR_W-1:0] REG_HEIGHT = 4'h4;
  localparam logic [CFG_ADDR_W-1:0] REG_SCALE = 4'h8;

  // Control sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_CALC,
    ST_WAIT
  } ctl_state_t;

  // Normal unit states.
  typedef enum logic [2:0] {
    NS_IDLE,
    NS_DIFF,
    NS_SQ,
    NS_SQRT,
    NS_DIV,
    NS_MAP,
    NS_DONE
  } nstate_t;

  // One normal to compute: neighbor greys plus tags.
  typedef struct packed {
    logic [GREY_W-1:0] gl;
    logic [GREY_W-1:0] gc;
    logic [GREY_W-1:0] gd;
    logic [SCALE_W-1:0] scale;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic last;
    logic eoi;
  } norm_job_t;

endpackage

### hdl/height_to_normal_map.sv
// Height map to normal map, top level: control, line buffer and output register.
// Depends on htnm_pkg, htnm_ram and htnm_norm.
//
// Usage: RGB pixels enter in raster order on the in_ stream, one transaction per
// pixel. Each pixel becomes a grey value stored in a one-row line memory. A pixel
// of row r > 0 produces the normal of (col, r-1); a pixel of the last row also
// produces its own normal, so it yields two out_ transactions. Row 0 of a taller
// image produces nothing.
// Each normal is computed by an iterative unit that steps through a start state,
// the differences, three squares, an iterative square root, three divides, the
// mapping of the three components and a done state. A pixel occupies the block
// until all its results are handed to the output register; a row-0 pixel of a
// taller image leaves it idle. in_tready is high only when the block is idle. A
// result waits in the output register while out_tready is low, and the sequencer
// holds the next normal until the register is free.
// Reset (rst_n low, synchronous) clears the counters, states, sequencer flags
// and out_tvalid; the job and output data registers are not cleared, nor is the
// line memory, which is written before it is read. Configuration uses the cfg_
// APB port; the user must write it only while the block is idle (not enforced).
module height_to_normal_map
  import htnm_pkg::*;
#(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,  // red, green, blue
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata, // normal_x, normal_y, normal_z, out_col(10), out_row(16), pad
  output logic [1:0]  out_tuser, // end_of_image
  output logic        out_tlast, // last_of_run
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int AW = $clog2(MAX_WIDTH);

  logic [WIDTH_REG_W-1:0] width_r;
  logic [ROW_W-1:0] height_r;
  logic [SCALE_W-1:0] scale_r;

  // Configuration registers.
  assign cfg_pready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r <= 11'd1024;
      height_r <= 16'd1;
      scale_r <= 9'd256;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      case (cfg_paddr)
        REG_WIDTH: width_r <= cfg_pwdata[WIDTH_REG_W-1:0];
        REG_HEIGHT: height_r <= cfg_pwdata[ROW_W-1:0];
        REG_SCALE: scale_r <= cfg_pwdata[SCALE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr)
      REG_WIDTH: cfg_prdata = 32'(width_r);
      REG_HEIGHT: cfg_prdata = 32'(height_r);
      REG_SCALE: cfg_prdata = 32'(scale_r);
      default: cfg_prdata = 32'd0;
    endcase
  end

  ctl_state_t state_r, state_nxt;
  logic [AW-1:0] col_r;
  logic [ROW_W-1:0] row_r;
  logic [GREY_W-1:0] pcent_r, pcur_r, g_r;
  logic second_r, need2_r;
  logic [GREY_W-1:0] g_in, gc;
  logic [9:0] rgb_sum;
  logic [AW:0] wlim;
  logic [ROW_W-1:0] hlim;
  logic row_end, last_row;
  logic accept, nstart, nbusy, ndone;
  norm_job_t job_r;
  logic [7:0] nx, ny, nz;
  logic ovalid_r;
  logic [55:0] odata_r;
  logic olast_r, oeoi_r;
  logic [GREY_W-1:0] pcur_prev_r;
  logic eoi2_r;

  // Divide by three through a reciprocal multiply; exact for sums up to 765.
  assign rgb_sum = 10'(in_tdata[7:0]) + 10'(in_tdata[15:8]) + 10'(in_tdata[23:16]);
  assign g_in = 8'((20'(rgb_sum) * 20'd683) >> 11);

  // Effective width and height limits.
  always_comb begin
    if (width_r == 11'd0) wlim = (AW+1)'(1);
    else if (32'(width_r) > MAX_WIDTH) wlim = (AW+1)'(MAX_WIDTH);
    else wlim = (AW+1)'(width_r);
    hlim = height_r == 16'd0 ? 16'd1 : height_r;
    row_end = (AW+1)'(col_r) >= wlim - (AW+1)'(1);
    last_row = row_r >= hlim - 16'd1;
  end

  assign in_tready = state_r == ST_IDLE;
  assign accept = in_tvalid && in_tready;

  htnm_ram #(.WIDTH(GREY_W), .DEPTH(MAX_WIDTH)) u_line (
    .clk(clk), .we(accept), .waddr(col_r), .wdata(g_in), .raddr(col_r), .rdata(gc)
  );

  htnm_norm u_norm (
    .clk(clk), .rst_n(rst_n), .start(nstart), .job(job_r), .busy(nbusy),
    .done(ndone), .nx(nx), .ny(ny), .nz(nz)
  );

  // Sequencer next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (accept) state_nxt = (row_r != 16'd0 || last_row) ? ST_READ : ST_IDLE;
      ST_READ: state_nxt = ST_CALC;
      ST_CALC: if (ndone) state_nxt = ST_WAIT;
      ST_WAIT: if (!ovalid_r || out_tready) state_nxt = need2_r ? ST_CALC : ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  assign nstart = state_r == ST_CALC && !nbusy && !ndone;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      col_r <= '0;
      row_r <= '0;
      pcent_r <= '0;
      pcur_r <= '0;
      ovalid_r <= 1'b0;
      need2_r <= 1'b0;
      second_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      // Output register: load a finished normal, or drop one that was taken.
      if (state_r == ST_WAIT && (!ovalid_r || out_tready)) begin
        ovalid_r <= 1'b1;
      end else if (out_tvalid && out_tready) begin
        ovalid_r <= 1'b0;
      end
      if (accept) begin
        g_r <= g_in;
        pcur_r <= g_in;
        job_r.scale <= scale_r;
        job_r.col <= COL_W'(col_r);
        second_r <= row_r != 16'd0;
        need2_r <= row_r != 16'd0 && last_row;
        // First job tags; for a pixel of row r > 0 the centre and left greys are filled at READ.
        job_r.row <= row_r != 16'd0 ? row_r - 16'd1 : row_r;
        job_r.last <= row_r != 16'd0 ? !last_row : 1'b1;
        job_r.eoi <= row_r != 16'd0 ? 1'b0 : row_end;
        job_r.gl <= (col_r != '0 && row_r == 16'd0) ? pcur_r : g_in;
        job_r.gc <= g_in;
        job_r.gd <= g_in;
        if (row_end) begin
          col_r <= '0;
          row_r <= last_row ? 16'd0 : row_r + 16'd1;
        end else begin
          col_r <= col_r + AW'(1);
        end
      end
      if (state_r == ST_READ && second_r) begin
        job_r.gc <= gc;
        job_r.gl <= job_r.col == '0 ? gc : pcent_r;
        pcent_r <= gc;
      end
      if (state_r == ST_WAIT && (!ovalid_r || out_tready)) begin
        odata_r <= {6'd0, job_r.row, job_r.col, nz, ny, nx};
        olast_r <= job_r.last;
        oeoi_r <= job_r.eoi;
        if (need2_r) begin
          need2_r <= 1'b0;
          job_r.gl <= job_r.col == '0 ? g_r : pcur_prev_r;
          job_r.gc <= g_r;
          job_r.gd <= g_r;
          job_r.row <= job_r.row + 16'd1;
          job_r.last <= 1'b1;
          job_r.eoi <= eoi2_r;
        end
      end
    end
  end

  // Left neighbor and end flag for the own-row result of a last-row pixel.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pcur_prev_r <= '0;
      eoi2_r <= 1'b0;
    end else if (accept) begin
      pcur_prev_r <= pcur_r;
      eoi2_r <= row_end;
    end
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata = odata_r;
  assign out_tlast = olast_r;
  assign out_tuser = {1'b0, oeoi_r};

`ifndef ASSERT_OFF
  // Inputs are taken only while no result is pending in the sequencer.
  a_idle_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> state_r == ST_IDLE) else $error("accept outside idle");
  // A held result must not change.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> $stable(out_tdata)) else $error("result changed");
  // The normal unit finishes only while the sequencer waits for it.
  a_done_calc: assert property (@(posedge clk) disable iff (!rst_n)
    ndone |-> state_r == ST_CALC) else $error("stray normal");
`endif

endmodule

### hdl/htnm_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
module htnm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hdl/htnm_norm.sv
// Iterative normal unit: differences, square root of the squared length, then three divides and mapping.
// Depends on htnm_pkg.
module htnm_norm
  import htnm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  norm_job_t   job,
  output logic        busy,
  output logic        done,
  output logic [7:0]  nx,
  output logic [7:0]  ny,
  output logic [7:0]  nz
);

  nstate_t state_r, state_nxt;

  // Signed Q16 parts (|dx| <= 65536, z <= 65536).
  logic signed [17:0] dx_r, dy_r, dz_r;
  logic [35:0] sum_r;
  logic [35:0] sq_v_r, sq_res_r, sq_bit_r;
  logic [17:0] len_r;
  logic [1:0] part_r;
  logic [5:0] step_r;
  logic [34:0] rem_r;
  logic [33:0] quo_r;
  logic [16:0] num_r;
  logic neg_r;
  logic signed [18:0] n_r [3];
  logic [7:0] nx_r, ny_r, nz_r;
  logic [1:0] sqi_r;

  // Truncated division by 255 of d*65536 for |d| <= 255.
  // Since 65536 = 255*257 + 1, the quotient is m*257, plus one only when m is 255.
  function automatic logic signed [17:0] div255(input logic signed [8:0] d);
    logic [7:0] m;
    logic [16:0] q;
    begin
      m = d[8] ? 8'((-d)) : d[7:0];
      q = 17'(m) * 17'd257 + ((m == 8'd255) ? 17'd1 : 17'd0);
      div255 = d[8] ? -18'(q) : 18'(q);
    end
  endfunction

  logic signed [8:0] ddx, ddy;
  assign ddx = 9'(job.gl) - 9'(job.gc);
  assign ddy = 9'(job.gd) - 9'(job.gc);

  logic [35:0] sq_t;
  logic [35:0] abs_sq;
  logic signed [18:0] mapped;
  logic [26:0] scaled;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      NS_IDLE: if (start) state_nxt = NS_DIFF;
      NS_DIFF: state_nxt = NS_SQ;
      NS_SQ: if (sqi_r == 2'd2) state_nxt = NS_SQRT;
      NS_SQRT: if (sq_bit_r == 36'd0) state_nxt = NS_DIV;
      NS_DIV: if (part_r == 2'd2 && step_r == 6'd0) state_nxt = NS_MAP;
      NS_MAP: if (part_r == 2'd2) state_nxt = NS_DONE;
      NS_DONE: state_nxt = NS_IDLE;
      default: state_nxt = NS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= NS_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    case (sqi_r)
      2'd0: abs_sq = 36'(dx_r[17] ? -dx_r : dx_r);
      2'd1: abs_sq = 36'(dy_r[17] ? -dy_r : dy_r);
      default: abs_sq = 36'(dz_r);
    endcase
    sq_t = abs_sq[17:0] * abs_sq[17:0];
    mapped = n_r[part_r] + 19'sd65536;
    scaled = 27'($unsigned(mapped[17:0]) * 27'd127);
  end

  // Datapath steps.
  always_ff @(posedge clk) begin
    case (state_r)
      NS_IDLE: begin
        sqi_r <= 2'd0;
        sum_r <= 36'd0;
      end
      NS_DIFF: begin
        dx_r <= div255(ddx);
        dy_r <= div255(ddy);
        dz_r <= 18'({job.scale > 9'd256 ? 9'd256 : job.scale, 8'd0});
      end
      NS_SQ: begin
        sum_r <= sum_r + sq_t;
        sqi_r <= sqi_r + 2'd1;
        if (sqi_r == 2'd2) begin
          sq_v_r <= sum_r + sq_t;
          sq_res_r <= 36'd0;
          sq_bit_r <= 36'h4_0000_0000;
        end
      end
      NS_SQRT: begin
        if (sq_bit_r != 36'd0) begin
          if (sq_v_r >= sq_res_r + sq_bit_r) begin
            sq_v_r <= sq_v_r - (sq_res_r + sq_bit_r);
            sq_res_r <= (sq_res_r >> 1) + sq_bit_r;
          end else begin
            sq_res_r <= sq_res_r >> 1;
          end
          sq_bit_r <= sq_bit_r >> 2;
        end else begin
          len_r <= sq_res_r[17:0];
          part_r <= 2'd0;
          step_r <= 6'd34;
          rem_r <= 35'd0;
          // Dividend is |part| * 65536.
          quo_r <= {1'b0, dx_r[17] ? 17'(-dx_r) : dx_r[16:0], 16'd0};
          neg_r <= dx_r[17];
        end
      end
      NS_DIV: begin
        if (step_r != 6'd0) begin
          if ({rem_r[33:0], quo_r[33]} >= 35'(len_r)) begin
            rem_r <= {rem_r[33:0], quo_r[33]} - 35'(len_r);
            quo_r <= {quo_r[32:0], 1'b1};
          end else begin
            rem_r <= {rem_r[33:0], quo_r[33]};
            quo_r <= {quo_r[32:0], 1'b0};
          end
          step_r <= step_r - 6'd1;
        end else begin
          n_r[part_r] <= neg_r ? -19'(quo_r[17:0]) : 19'(quo_r[17:0]);
          part_r <= part_r + 2'd1;
          step_r <= 6'd34;
          rem_r <= 35'd0;
          if (part_r == 2'd0) begin
            quo_r <= {1'b0, dy_r[17] ? 17'(-dy_r) : dy_r[16:0], 16'd0};
            neg_r <= dy_r[17];
          end else begin
            quo_r <= {1'b0, dz_r[16:0], 16'd0};
            neg_r <= 1'b0;
          end
          if (part_r == 2'd2) part_r <= 2'd0;
        end
      end
      NS_MAP: begin
        case (part_r)
          2'd0: nx_r <= len_r == 18'd0 ? 8'd127 : scaled[23:16];
          2'd1: ny_r <= len_r == 18'd0 ? 8'd127 : scaled[23:16];
          default: nz_r <= len_r == 18'd0 ? 8'd127 : scaled[23:16];
        endcase
        part_r <= part_r + 2'd1;
      end
      default: begin
      end
    endcase
  end

  assign busy = state_r != NS_IDLE;
  assign done = state_r == NS_DONE;
  assign nx = nx_r;
  assign ny = ny_r;
  assign nz = nz_r;

endmodule
